// ===== sv/acsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acsc_pkg: shared types and constants of the alarm clock setting controller
// Holds the input and result word types, the mode, event and key codes and
// the BCD digit limits used by the editing logic.
// ----------------------------------------------------------------------------
package acsc_pkg;

    // Width of a stored time in BCD HHMMSS, six nibbles.
    localparam int TIME_W     = 24;
    // Width of a time as it travels on the ports.
    localparam int PORT_TIME_W = 22;
    localparam int DIGITS     = 6;

    // Digit limits.
    localparam logic [2:0] CURSOR_MAX = 3'd5;
    localparam logic [3:0] UNITS_MAX  = 4'd9;
    localparam logic [3:0] TENS_MAX   = 4'd5;
    localparam logic [3:0] HOUR_T_MAX = 4'd2;
    localparam logic [3:0] HOUR_U_LIM = 4'd3;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_SHOW       = 3'd1,
        MODE_ALARM_EDIT = 3'd2,
        MODE_CLOCK_EDIT = 3'd3,
        MODE_TOGGLE     = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        REP_SHOW = 2'd0,
        REP_ASET = 2'd1,
        REP_TSET = 2'd2
    } rep_kind_t;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_TIME    = 2'd2
    } ev_kind_t;

    typedef enum logic [2:0] {
        KEY_SET_TIME  = 3'd0,
        KEY_SET_ALARM = 3'd1,
        KEY_LEFT      = 3'd2,
        KEY_RIGHT     = 3'd3,
        KEY_UP        = 3'd4,
        KEY_DOWN      = 3'd5
    } key_t;

    typedef struct packed {
        logic [1:0]             kind;
        logic [2:0]             key;
        logic [PORT_TIME_W-1:0] time_value;
    } in_word_t;

    typedef struct packed {
        logic                   report_valid;
        logic [1:0]             report_kind;
        logic [PORT_TIME_W-1:0] report_value;
        logic                   alarm_enabled;
        logic [2:0]             mode_now;
        logic [2:0]             cursor_now;
        logic [PORT_TIME_W-1:0] clock_shown;
        logic [PORT_TIME_W-1:0] alarm_shown;
    } out_word_t;

endpackage
`default_nettype wire

// ===== sv/acsc_digit_edit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acsc_digit_edit: raise or lower one BCD digit of a time
// Picks the nibble under the cursor, checks the hour, minute and second
// limits, and returns the edited time with a flag saying whether it moved.
// ----------------------------------------------------------------------------
module acsc_digit_edit (
    input  wire logic [acsc_pkg::TIME_W-1:0] time_in,
    input  wire logic [2:0]                  cursor,
    input  wire logic                        up,
    output      logic [acsc_pkg::TIME_W-1:0] time_out,
    output      logic                        changed
);

    logic [3:0] digit;
    logic [3:0] hour_t;
    logic [3:0] hour_u;
    logic       up_ok;
    logic [3:0] digit_new;

    assign hour_t = time_in[23:20];
    assign hour_u = time_in[19:16];

    // Select the digit under the cursor and work out whether it may rise.
    always_comb
    begin
        digit = 4'd0;
        up_ok = 1'b0;
        unique case (cursor)
            3'd0:
            begin
                digit = time_in[3:0];
                up_ok = digit < acsc_pkg::UNITS_MAX;
            end
            3'd1:
            begin
                digit = time_in[7:4];
                up_ok = digit < acsc_pkg::TENS_MAX;
            end
            3'd2:
            begin
                digit = time_in[11:8];
                up_ok = digit < acsc_pkg::UNITS_MAX;
            end
            3'd3:
            begin
                digit = time_in[15:12];
                up_ok = digit < acsc_pkg::TENS_MAX;
            end
            3'd4:
            begin
                digit = hour_u;
                up_ok = (digit < acsc_pkg::HOUR_U_LIM && hour_t <= acsc_pkg::HOUR_T_MAX) ||
                        (digit < acsc_pkg::UNITS_MAX && hour_t <= 4'd1);
            end
            3'd5:
            begin
                digit = hour_t;
                up_ok = (digit < 4'd2 && hour_u < 4'd4) || digit < 4'd1;
            end
            default:
            begin
                digit = 4'd0;
                up_ok = 1'b0;
            end
        endcase
    end

    // A lowered digit never borrows; a raised digit never carries.
    assign changed   = up ? up_ok : (digit != 4'd0);
    assign digit_new = up ? (digit + 4'd1) : (digit - 4'd1);

    // Put the new digit back in its place.
    for (genvar i = 0; i < acsc_pkg::DIGITS; i++)
    begin : g_nib
        assign time_out[i*4 +: 4] = (changed && cursor == 3'(i)) ? digit_new
                                                                 : time_in[i*4 +: 4];
    end

endmodule
`default_nettype wire

// ===== sv/acsc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acsc_ctrl: mode, cursor, time and report state of the controller
// Holds the setting state and applies one event word per fire, producing
// the result word from the updated state.
// ----------------------------------------------------------------------------
module acsc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 fire,
    input  wire acsc_pkg::in_word_t   ev,
    output      acsc_pkg::out_word_t  result
);

    acsc_pkg::mode_t                  mode_reg,     mode_next;
    logic [2:0]                       cursor_reg,   cursor_next;
    logic [acsc_pkg::TIME_W-1:0]      clock_reg,    clock_next;
    logic [acsc_pkg::TIME_W-1:0]      alarm_reg,    alarm_next;
    logic                             flag_reg,     flag_next;
    logic [acsc_pkg::TIME_W-1:0]      rep_value_reg, rep_value_next;
    logic [1:0]                       rep_kind_reg, rep_kind_next;
    logic                             valid;

    logic                             edit_alarm;
    logic [acsc_pkg::TIME_W-1:0]      edit_in;
    logic [acsc_pkg::TIME_W-1:0]      edit_out;
    logic                             edit_changed;
    logic                             set_mode;

    // The digit editor works on the alarm time in alarm set, else the clock.
    assign edit_alarm = (mode_reg == acsc_pkg::MODE_ALARM_EDIT);
    assign edit_in    = edit_alarm ? alarm_reg : clock_reg;
    assign set_mode   = (mode_reg == acsc_pkg::MODE_ALARM_EDIT) ||
                        (mode_reg == acsc_pkg::MODE_CLOCK_EDIT);

    acsc_digit_edit u_edit (
        .time_in  (edit_in),
        .cursor   (cursor_reg),
        .up       (ev.key == acsc_pkg::KEY_UP),
        .time_out (edit_out),
        .changed  (edit_changed)
    );

    // Next state for one event word.
    always_comb
    begin
        mode_next      = mode_reg;
        cursor_next    = cursor_reg;
        clock_next     = clock_reg;
        alarm_next     = alarm_reg;
        flag_next      = flag_reg;
        rep_value_next = rep_value_reg;
        rep_kind_next  = rep_kind_reg;
        valid          = 1'b0;
        unique case (ev.kind)
            acsc_pkg::EV_PRESS:
            begin
                unique case (ev.key)
                    acsc_pkg::KEY_SET_TIME:
                    begin
                        if (mode_reg == acsc_pkg::MODE_SHOW)
                        begin
                            mode_next = acsc_pkg::MODE_CLOCK_EDIT;
                        end
                        else if (mode_reg == acsc_pkg::MODE_ALARM_EDIT)
                        begin
                            mode_next      = acsc_pkg::MODE_TOGGLE;
                            flag_next      = ~flag_reg;
                            rep_value_next = alarm_reg;
                            rep_kind_next  = acsc_pkg::REP_SHOW;
                            valid          = 1'b1;
                        end
                    end
                    acsc_pkg::KEY_SET_ALARM:
                    begin
                        if (mode_reg == acsc_pkg::MODE_SHOW)
                        begin
                            mode_next = acsc_pkg::MODE_ALARM_EDIT;
                        end
                        else if (mode_reg == acsc_pkg::MODE_CLOCK_EDIT)
                        begin
                            mode_next      = acsc_pkg::MODE_TOGGLE;
                            flag_next      = ~flag_reg;
                            rep_value_next = clock_reg;
                            rep_kind_next  = acsc_pkg::REP_SHOW;
                            valid          = 1'b1;
                        end
                    end
                    acsc_pkg::KEY_LEFT:
                    begin
                        if (set_mode && cursor_reg < acsc_pkg::CURSOR_MAX)
                        begin
                            cursor_next = cursor_reg + 3'd1;
                        end
                    end
                    acsc_pkg::KEY_RIGHT:
                    begin
                        if (set_mode && cursor_reg != 3'd0)
                        begin
                            cursor_next = cursor_reg - 3'd1;
                        end
                    end
                    acsc_pkg::KEY_UP, acsc_pkg::KEY_DOWN:
                    begin
                        // Up always reports in a set mode; down only when it moved.
                        if (set_mode &&
                            (ev.key == acsc_pkg::KEY_UP || edit_changed))
                        begin
                            if (edit_alarm)
                            begin
                                alarm_next    = edit_out;
                                rep_kind_next = acsc_pkg::REP_ASET;
                            end
                            else
                            begin
                                clock_next    = edit_out;
                                rep_kind_next = acsc_pkg::REP_TSET;
                            end
                            rep_value_next = edit_out;
                            valid          = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            acsc_pkg::EV_RELEASE:
            begin
                if (ev.key == acsc_pkg::KEY_SET_TIME)
                begin
                    if (mode_reg == acsc_pkg::MODE_CLOCK_EDIT)
                    begin
                        mode_next      = acsc_pkg::MODE_SHOW;
                        cursor_next    = 3'd0;
                        rep_value_next = clock_reg;
                        rep_kind_next  = acsc_pkg::REP_SHOW;
                        valid          = 1'b1;
                    end
                    else if (mode_reg == acsc_pkg::MODE_TOGGLE)
                    begin
                        mode_next = acsc_pkg::MODE_ALARM_EDIT;
                    end
                end
                else if (ev.key == acsc_pkg::KEY_SET_ALARM)
                begin
                    // The report is latched here but not flagged as valid.
                    if (mode_reg == acsc_pkg::MODE_ALARM_EDIT)
                    begin
                        mode_next      = acsc_pkg::MODE_SHOW;
                        cursor_next    = 3'd0;
                        rep_value_next = alarm_reg;
                        rep_kind_next  = acsc_pkg::REP_SHOW;
                    end
                    else if (mode_reg == acsc_pkg::MODE_TOGGLE)
                    begin
                        mode_next = acsc_pkg::MODE_CLOCK_EDIT;
                    end
                end
            end
            acsc_pkg::EV_TIME:
            begin
                if (mode_reg != acsc_pkg::MODE_CLOCK_EDIT)
                begin
                    clock_next = {2'b00, ev.time_value};
                end
            end
            default:
            begin
            end
        endcase
    end

    // State registers, updated once per processed word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= acsc_pkg::MODE_SHOW;
            cursor_reg    <= 3'd0;
            clock_reg     <= '0;
            alarm_reg     <= '0;
            flag_reg      <= 1'b0;
            rep_value_reg <= '0;
            rep_kind_reg  <= acsc_pkg::REP_SHOW;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            cursor_reg    <= cursor_next;
            clock_reg     <= clock_next;
            alarm_reg     <= alarm_next;
            flag_reg      <= flag_next;
            rep_value_reg <= rep_value_next;
            rep_kind_reg  <= rep_kind_next;
        end
    end

    // Result word shows the state after this event.
    always_comb
    begin
        result.report_valid  = valid;
        result.report_kind   = rep_kind_next;
        result.report_value  = rep_value_next[acsc_pkg::PORT_TIME_W-1:0];
        result.alarm_enabled = flag_next;
        result.mode_now      = mode_next;
        result.cursor_now    = cursor_next;
        result.clock_shown   = clock_next[acsc_pkg::PORT_TIME_W-1:0];
        result.alarm_shown   = alarm_next[acsc_pkg::PORT_TIME_W-1:0];
    end

endmodule
`default_nettype wire

// ===== sv/alarm_clock_setting_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// alarm_clock_setting_controller: key and time event controller
// Registers each event word, applies it to the setting state and registers
// the resulting display and report word.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Word
//  --------+-----------+----------------------+---------------------
//  in      | input     | in_valid / in_ready  | acsc_pkg::in_word_t
//  out     | output    | out_valid / out_ready| acsc_pkg::out_word_t
//
// One word is processed per clock cycle while the output is not stalled; an
// accepted word passes through the input register, then the result register.
// The state update and result are combinational between those registers.
// Reset puts the controller in show mode with both times, the cursor, the
// alarm flag and the latched report cleared.
// A stalled output holds its result and the input register holds at most one
// further word; in_ready is low while both are full and out_ready is low.
// ----------------------------------------------------------------------------
module alarm_clock_setting_controller (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire acsc_pkg::in_word_t  in_data,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      acsc_pkg::out_word_t out_data
);

    logic                in_valid_reg;
    acsc_pkg::in_word_t  in_data_reg;
    logic                out_valid_reg;
    acsc_pkg::out_word_t out_data_reg;
    acsc_pkg::out_word_t result;
    logic                advance;
    logic                fire;

    // The result register can take a new word when it is empty or being read.
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_data_reg <= in_data;
        end
    end

    acsc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .ev     (in_data_reg),
        .result (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire
